FILE: hw/rtl/stfb_pkg.sv
// ----------------------------------------------------------------------------
// stfb_pkg
// Shared widths, reset values and register indexes for the frame blend.
// ----------------------------------------------------------------------------
package stfb_pkg;

  localparam int PIX_W   = 32;
  localparam int NBYTES  = 4;
  localparam int THR_W   = 7;
  localparam int WGT_W   = 8;

  localparam logic [THR_W-1:0] LOW_RST  = 7'd4;
  localparam logic [THR_W-1:0] HIGH_RST = 7'd8;

  localparam logic [7:0] CENTER  = 8'd128;
  localparam logic [7:0] WGT_MAX = 8'd255;

  typedef enum logic [0:0] {
    CFG_LOW  = 1'b0,
    CFG_HIGH = 1'b1
  } cfg_idx_t;

endpackage

FILE: hw/rtl/stfb_if.sv
// ----------------------------------------------------------------------------
// stfb_in_if / stfb_out_if
// Valid/ready channels carrying the pixel beats into and out of the blend.
// ----------------------------------------------------------------------------
interface stfb_in_if;
  import stfb_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] diff_pixel;
  logic [PIX_W-1:0] cur_pixel;
  logic [PIX_W-1:0] next_pixel;

  modport source (output valid, output diff_pixel, output cur_pixel, output next_pixel,
                  input ready);
  modport sink   (input valid, input diff_pixel, input cur_pixel, input next_pixel,
                  output ready);
endinterface

interface stfb_out_if;
  import stfb_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic [WGT_W-1:0] blend_weight;

  modport source (output valid, output out_pixel, output blend_weight, input ready);
  modport sink   (input valid, input out_pixel, input blend_weight, output ready);
endinterface

FILE: hw/rtl/soft_threshold_frame_blend.sv
// ----------------------------------------------------------------------------
// soft_threshold_frame_blend
// Motion adaptive blend of a current pixel toward the next frame's pixel.
//
// Input channel in_if carries one beat per pixel: diff_pixel (four bytes
// centered on 128), cur_pixel and next_pixel. Output channel out_if returns
// one beat per input beat, in order: out_pixel and blend_weight.
// The weight is the ramp of the largest byte distance from 128 between the
// low and high thresholds, written on the cfg_ port (index 0 low, 1 high)
// while no beats are in flight.
// Eight register stages: distance max, ramp setup, four stages of a radix-4
// restoring divider (two quotient bits each), blend multiply, select/output.
// A beat accepted into stage 0 is presented on out_if from stage 7.
// Throughput is one beat per cycle while out_if does not stall; the divider
// and multiplier lanes are fully pipelined.
// Each stage holds its beat when the next one is full, so out_if stalls
// back up stage by stage and bubbles are squeezed out; in_if.ready drops
// only once all eight stages hold beats.
// Synchronous reset empties the pipeline and loads thresholds 4 and 8.
// ----------------------------------------------------------------------------
module soft_threshold_frame_blend (
  input  logic                           clk,
  input  logic                           rst_n,
  stfb_in_if.sink                        in_if,
  stfb_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  stfb_pkg::cfg_idx_t             cfg_index,
  input  logic [stfb_pkg::THR_W-1:0]     cfg_wdata
);
  import stfb_pkg::*;

  localparam int NSTG = 8;
  localparam int NDIV = 4;

  logic [THR_W-1:0] low_r;
  logic [THR_W-1:0] high_r;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] ld;

  // stage 0
  logic [7:0]       dmax_nxt;
  logic [7:0]       dmax_r;
  // stages 0..5 pixel carry
  logic [PIX_W-1:0] cur_r [0:5];
  logic [PIX_W-1:0] nxt_r [0:5];
  // stages 1..5 divider
  logic [14:0]      rem_r  [1:5];
  logic [7:0]       q_r    [1:5];
  logic [6:0]       span_r [1:5];
  logic             zero_r [1:5];
  logic             full_r [1:5];
  // stage 6
  logic signed [18:0] prod_r [0:NBYTES-1];
  logic [PIX_W-1:0]   cur6_r;
  logic [PIX_W-1:0]   nxt6_r;
  logic [WGT_W-1:0]   w6_r;
  // stage 7
  logic [PIX_W-1:0]   pix7_r;
  logic [WGT_W-1:0]   w7_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= LOW_RST;
      high_r <= HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW:  low_r  <= cfg_wdata;
        CFG_HIGH: high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage load enables
  always_comb begin
    ld[NSTG-1] = !v_r[NSTG-1] || out_if.ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_if.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_if.ready = ld[0];

  // stage 0: largest distance from center
  always_comb begin
    logic [7:0] b;
    logic [7:0] d;
    dmax_nxt = '0;
    for (int k = 0; k < NBYTES; k++) begin
      b = in_if.diff_pixel[8*k +: 8];
      d = b[7] ? (b - CENTER) : (CENTER - b);
      if (d > dmax_nxt) begin
        dmax_nxt = d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      dmax_r   <= dmax_nxt;
      cur_r[0] <= in_if.cur_pixel;
      nxt_r[0] <= in_if.next_pixel;
    end
  end

  // stage 1: ramp region and dividend
  logic [7:0]  hi_eff;
  logic [6:0]  x1;
  logic [14:0] num1;
  logic [6:0]  span1;

  always_comb begin
    hi_eff = (high_r == low_r) ? ({1'b0, low_r} + 8'd1) : {1'b0, high_r};
    x1     = 7'(dmax_r - {1'b0, low_r});
    span1  = 7'(hi_eff - {1'b0, low_r});
    num1   = {x1, 8'h00} - 15'(x1);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      zero_r[1] <= (dmax_r <= {1'b0, low_r});
      full_r[1] <= (dmax_r > hi_eff);
      rem_r[1]  <= num1;
      q_r[1]    <= '0;
      span_r[1] <= span1;
      cur_r[1]  <= cur_r[0];
      nxt_r[1]  <= nxt_r[0];
    end
  end

  // stages 2..5: two quotient bits per stage
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    localparam int SH = 2*(NDIV-1-j) + 1;
    logic [14:0] dh;
    logic [14:0] dl;
    logic [14:0] t1;
    logic [14:0] t2;
    logic        b1;
    logic        b2;

    always_comb begin
      dh = 15'(span_r[j+1]) << SH;
      dl = 15'(span_r[j+1]) << (SH-1);
      b1 = rem_r[j+1] >= dh;
      t1 = b1 ? (rem_r[j+1] - dh) : rem_r[j+1];
      b2 = t1 >= dl;
      t2 = b2 ? (t1 - dl) : t1;
    end

    always_ff @(posedge clk) begin
      if (ld[j+2]) begin
        rem_r[j+2]  <= t2;
        q_r[j+2]    <= {q_r[j+1][5:0], b1, b2};
        span_r[j+2] <= span_r[j+1];
        zero_r[j+2] <= zero_r[j+1];
        full_r[j+2] <= full_r[j+1];
        cur_r[j+2]  <= cur_r[j+1];
        nxt_r[j+2]  <= nxt_r[j+1];
      end
    end
  end

  // stage 6: weight and per-byte products
  logic [WGT_W-1:0] w5;
  logic [8:0]       a5;
  assign w5 = zero_r[5] ? '0 : (full_r[5] ? WGT_MAX : q_r[5]);
  assign a5 = {1'b0, w5} + 9'd1;

  for (genvar k = 0; k < NBYTES; k++) begin : g_mul
    logic signed [8:0] dn;
    assign dn = $signed({1'b0, nxt_r[5][8*k +: 8]}) - $signed({1'b0, cur_r[5][8*k +: 8]});

    always_ff @(posedge clk) begin
      if (ld[6]) begin
        prod_r[k] <= $signed({1'b0, a5}) * dn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      cur6_r <= cur_r[5];
      nxt6_r <= nxt_r[5];
      w6_r   <= w5;
    end
  end

  // stage 7: floor shift, add, select
  logic [PIX_W-1:0] pix_nxt;

  always_comb begin
    logic signed [18:0] sh;
    logic [PIX_W-1:0]   mix;
    mix = '0;
    for (int k = 0; k < NBYTES; k++) begin
      sh = prod_r[k] >>> 8;
      mix[8*k +: 8] = cur6_r[8*k +: 8] + sh[7:0];
    end
    if (w6_r == '0) begin
      pix_nxt = cur6_r;
    end else if (w6_r == WGT_MAX) begin
      pix_nxt = nxt6_r;
    end else begin
      pix_nxt = mix;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      pix7_r <= pix_nxt;
      w7_r   <= w6_r;
    end
  end

  assign out_if.valid        = v_r[NSTG-1];
  assign out_if.out_pixel    = pix7_r;
  assign out_if.blend_weight = w7_r;

  // checks
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] && !zero_r[5] && !full_r[5] |-> rem_r[5] < 15'(span_r[5]))
    else $error("divider remainder not below span");

  // both regions only when high sits below low
  a_region_excl: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && zero_r[1] && full_r[1] |-> high_r < low_r)
    else $error("zero and full regions both set with a ramp");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> v_r[0])
    else $error("accepted beat missing from first stage");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[6] && !ld[6] |=> v_r[6] && $stable(w6_r))
    else $error("stalled blend stage lost its beat");

endmodule

FILE: verif/soft_threshold_frame_blend_test.sv
// ----------------------------------------------------------------------------
// soft_threshold_frame_blend_test
// Drives pixel beats through the frame blend under bursty input and a
// stalling sink, predicts each weight and blended pixel from its own copy of
// the thresholds, and checks every output beat in order. Threshold pairs
// cover both extremes, equal values and a high below the low.
// ----------------------------------------------------------------------------
module soft_threshold_frame_blend_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stfb_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] diff;
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] nxt;
  } pixel_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic [WGT_W-1:0] blend_weight;
  } blend_result_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_TOGGLE,
    SINK_HEAVY
  } sink_mode_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [THR_W-1:0] cfg_wdata;

  stfb_in_if  in_if();
  stfb_out_if out_if();

  soft_threshold_frame_blend uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pixel_beat_t   pending_pixels[$];
  blend_result_t expected_blends[$];
  pixel_beat_t   driven_beat;
  logic [THR_W-1:0] low_thr  = LOW_RST;
  logic [THR_W-1:0] high_thr = HIGH_RST;
  int burst_left;
  int gap_left;
  int hold_left;
  int sink_cycle;
  sink_mode_t sink_mode;
  int blends_checked = 0;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic blend_result_t predict_blend(pixel_beat_t b, logic [THR_W-1:0] lo,
                                                  logic [THR_W-1:0] hi);
    int lo_i, hi_i, d, m, w, c, n, p, k;
    blend_result_t r;
    lo_i = int'(lo);
    hi_i = (hi == lo) ? lo_i + 1 : int'(hi);
    w = 0;
    for (k = 0; k < NBYTES; k++) begin
      d = int'(b.diff[8*k +: 8]);
      d = (d >= CENTER) ? d - CENTER : CENTER - d;
      if (d <= lo_i) m = 0;
      else if (d <= hi_i) m = (WGT_MAX * (d - lo_i)) / (hi_i - lo_i);
      else m = WGT_MAX;
      if (m > w) w = m;
    end
    r.blend_weight = WGT_W'(w);
    if (w == 0) begin
      r.out_pixel = b.cur;
    end else if (w == WGT_MAX) begin
      r.out_pixel = b.nxt;
    end else begin
      for (k = 0; k < NBYTES; k++) begin
        c = int'(b.cur[8*k +: 8]);
        n = int'(b.nxt[8*k +: 8]);
        p = (w + 1) * (n - c);
        r.out_pixel[8*k +: 8] = 8'(c + (p >>> 8));
      end
    end
    return r;
  endfunction

  // difference word: mostly quiet lanes with one or more near the ramp, or fully random bytes
  function automatic logic [PIX_W-1:0] make_diff(int lo, int hi);
    int reach, kind, lane, d, k;
    logic [PIX_W-1:0] v;
    reach = ((lo > hi) ? lo : hi) + 3;
    if (reach > 128) reach = 128;
    kind = $urandom_range(0, 9);
    lane = $urandom_range(0, NBYTES - 1);
    for (k = 0; k < NBYTES; k++) begin
      if (kind >= 7) begin
        v[8*k +: 8] = 8'($urandom_range(0, 255));
      end else begin
        if (kind >= 2 && (k == lane || $urandom_range(0, 2) == 0)) d = $urandom_range(0, reach);
        else d = $urandom_range(0, lo);
        v[8*k +: 8] = 8'((d == 128 || $urandom_range(0, 1) == 1) ? 128 - d : 128 + d);
      end
    end
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] make_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_pixel(logic [PIX_W-1:0] d, logic [PIX_W-1:0] c, logic [PIX_W-1:0] n);
    pixel_beat_t b;
    b.diff = d;
    b.cur  = c;
    b.nxt  = n;
    pending_pixels.push_back(b);
  endtask

  // sampled at the falling edge so the driver's and monitor's updates have settled
  task automatic wait_idle();
    do
      @(negedge clk);
    while (pending_pixels.size() != 0 || in_if.valid || expected_blends.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_thresholds(int lo, int hi);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOW;
    cfg_wdata <= THR_W'(lo);
    @(posedge clk);
    cfg_index <= CFG_HIGH;
    cfg_wdata <= THR_W'(hi);
    @(posedge clk);
    cfg_we   <= 1'b0;
    low_thr  = THR_W'(lo);
    high_thr = THR_W'(hi);
  endtask

  // sender: bursts of beats separated by random gaps
  always @(posedge clk) begin : drive_pixels
    pixel_beat_t b;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left  <= $urandom_range(1, 40);
      gap_left    <= 0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_blends.push_back(predict_blend(driven_beat, low_thr, high_thr));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          in_if.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (pending_pixels.size() != 0) begin
          b = pending_pixels.pop_front();
          driven_beat       <= b;
          in_if.diff_pixel  <= b.diff;
          in_if.cur_pixel   <= b.cur;
          in_if.next_pixel  <= b.nxt;
          in_if.valid       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // sink: stall pattern is redrawn at random from four modes; two long hold-offs fill the pipe
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      sink_cycle   <= 0;
      sink_mode    <= SINK_OPEN;
    end else begin
      sink_cycle <= sink_cycle + 1;
      if (sink_cycle % 32 == 31) sink_mode <= sink_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (out_if.valid && out_if.ready &&
                   (blends_checked == 400 || blends_checked == 1100)) begin
        out_if.ready <= 1'b0;
        hold_left    <= 80;
      end else begin
        case (sink_mode)
          SINK_OPEN:   out_if.ready <= 1'b1;
          SINK_LIGHT:  out_if.ready <= ($urandom_range(0, 3) != 0);
          SINK_TOGGLE: out_if.ready <= ~out_if.ready;
          default:     out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_blends
    blend_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      blends_checked <= blends_checked + 1;
      if (expected_blends.size() == 0) begin
        $error("unexpected beat: out_pixel %h blend_weight %h",
               out_if.out_pixel, out_if.blend_weight);
        mismatch_count++;
      end else begin
        want = expected_blends.pop_front();
        if (out_if.out_pixel !== want.out_pixel) begin
          $error("out_pixel expected %h actual %h", want.out_pixel, out_if.out_pixel);
          mismatch_count++;
        end
        if (out_if.blend_weight !== want.blend_weight) begin
          $error("blend_weight expected %h actual %h", want.blend_weight,
                 out_if.blend_weight);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int phase_lo[10] = '{0, 0, 127, 127, 10, 5, 30, 0, 60, 0};
    int phase_hi[10] = '{0, 127, 127, 0, 20, 5, 10, 1, 90, 0};
    int lo, hi;
    logic [PIX_W-1:0] c;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_LOW;
    cfg_wdata        = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds 4 / 8
    queue_pixel(32'h80808080, 32'h00000000, 32'hFFFFFFFF);
    queue_pixel(32'h84847C84, 32'hFFFFFFFF, 32'h00000000);
    queue_pixel(32'h80808085, 32'h00000000, 32'hFFFFFFFF);
    queue_pixel(32'h80808580, 32'hFFFFFFFF, 32'h00000000);
    queue_pixel(32'h80868080, 32'h12345678, 32'h87654321);
    queue_pixel(32'h87808080, 32'hA5A5A5A5, 32'h5A5A5A5A);
    queue_pixel(32'h7B7A7980, 32'h00FF00FF, 32'hFF00FF00);
    queue_pixel(32'h80808088, 32'h01020304, 32'hFEFDFCFB);
    queue_pixel(32'h80808089, 32'h0F1E2D3C, 32'hC3D2E1F0);
    queue_pixel(32'h00000000, 32'h11223344, 32'h55667788);
    queue_pixel(32'hFFFFFFFF, 32'h99AABBCC, 32'hDDEEFF00);
    queue_pixel(32'h85868788, 32'h3C3C3C3C, 32'h3C3C3C3C);
    queue_pixel(32'h80808086, 32'h7F807F80, 32'h807F807F);
    queue_pixel(32'h7F818081, 32'h0000FFFF, 32'hFFFF0000);

    // equal thresholds: ramp collapses to a single step
    set_thresholds(5, 5);
    queue_pixel(32'h80808085, 32'h00000000, 32'hFFFFFFFF);
    queue_pixel(32'h80808086, 32'h00000000, 32'hFFFFFFFF);
    queue_pixel(32'h7A808080, 32'hFFFFFFFF, 32'h00000000);

    // high below low: no ramp at all
    set_thresholds(30, 10);
    queue_pixel(32'h9E808080, 32'h00000000, 32'hFFFFFFFF);
    queue_pixel(32'h9F808080, 32'h00000000, 32'hFFFFFFFF);
    queue_pixel(32'h8A616180, 32'h13579BDF, 32'h2468ACE0);

    for (int ph = 0; ph < 10; ph++) begin
      lo = phase_lo[ph];
      hi = phase_hi[ph];
      if (ph == 9) begin
        lo = $urandom_range(0, 127);
        hi = $urandom_range(0, 127);
      end
      set_thresholds(lo, hi);
      repeat (150) begin
        c = make_pixel();
        queue_pixel(make_diff(lo, hi), c, ($urandom_range(0, 9) == 0) ? c : make_pixel());
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("soft_threshold_frame_blend_test passed");
    end else begin
      $display("soft_threshold_frame_blend_test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("soft_threshold_frame_blend_test failed");
    $finish;
  end

endmodule
